### design/prrs_pkg.sv
// ----------------------------------------------------------------------------
// prrs_pkg: shared types and constants of the task scheduler
// Holds the task table sizes, the event and status codes, and the interface
// types between the scheduler's sequencer, its task table and its scan unit.
// ----------------------------------------------------------------------------
`default_nettype none

package prrs_pkg;

  localparam int TaskSlots = 8;
  localparam int IdxW      = $clog2(TaskSlots);
  localparam int CntW      = $clog2(TaskSlots + 1);
  localparam int PrioW     = 8;
  localparam int SliceW    = 16;

  localparam logic [SliceW-1:0] SliceReset = SliceW'(10);

  typedef enum logic [1:0] {
    FUNC_TICK   = 2'd0,
    FUNC_YIELD  = 2'd1,
    FUNC_CREATE = 2'd2,
    FUNC_SET    = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    TS_READY      = 2'd0,
    TS_RUNNING    = 2'd1,
    TS_BLOCKED    = 2'd2,
    TS_TERMINATED = 2'd3
  } task_state_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2,
    STAT_RSVD  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    SC_HOLD      = 2'd0,
    SC_START_PRI = 2'd1,
    SC_START_RR  = 2'd2,
    SC_STEP      = 2'd3
  } scan_cmd_e;

  // One write into the task table: state and, on creation, priority.
  typedef struct packed {
    logic              st_we;
    logic [IdxW-1:0]   addr;
    task_state_e       st_data;
    logic              pr_we;
    logic [PrioW-1:0]  pr_data;
  } tbl_wr_t;

  // What the scan unit reports about the entry under its pointer.
  typedef struct packed {
    logic [IdxW-1:0] ptr;
    logic            hit;
    logic            last;
    logic            found;
    logic [IdxW-1:0] best;
  } scan_stat_t;

  // Next task index, wrapping to zero at the task count.
  function automatic logic [IdxW-1:0] wrap_inc(input logic [IdxW-1:0] idx,
                                               input logic [CntW-1:0] cnt);
    logic [CntW-1:0] nxt;
    nxt = CntW'(idx) + CntW'(1);
    return (nxt == cnt) ? '0 : IdxW'(nxt);
  endfunction

endpackage

`default_nettype wire

### design/prrs_table.sv
// ----------------------------------------------------------------------------
// prrs_table: task state and priority table
// One write port and one read address per cycle. States reset to terminated;
// priorities are only read for created tasks and need no reset.
// ----------------------------------------------------------------------------
`default_nettype none

module prrs_table (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire prrs_pkg::tbl_wr_t           wr_i,
  input  wire logic [prrs_pkg::IdxW-1:0]   rd_addr_i,
  output prrs_pkg::task_state_e            rd_status_o,
  output logic [prrs_pkg::PrioW-1:0]       rd_prio_o
);

  prrs_pkg::task_state_e          status_q [prrs_pkg::TaskSlots];
  logic [prrs_pkg::PrioW-1:0]     prio_q   [prrs_pkg::TaskSlots];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < prrs_pkg::TaskSlots; i++) begin
        status_q[i] <= prrs_pkg::TS_TERMINATED;
      end
    end else if (wr_i.st_we) begin
      status_q[wr_i.addr] <= wr_i.st_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.pr_we) begin
      prio_q[wr_i.addr] <= wr_i.pr_data;
    end
  end

  assign rd_status_o = status_q[rd_addr_i];
  assign rd_prio_o   = prio_q[rd_addr_i];

endmodule

`default_nettype wire

### design/prrs_scan.sv
// ----------------------------------------------------------------------------
// prrs_scan: shared scan unit of the scheduler
// Walks the table one entry per cycle when stepped, from entry zero keeping
// the best ready priority, or round-robin from a given start entry.
// ----------------------------------------------------------------------------
`default_nettype none

module prrs_scan (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire prrs_pkg::scan_cmd_e         cmd_i,
  input  wire logic [prrs_pkg::IdxW-1:0]   start_i,
  input  wire logic [prrs_pkg::CntW-1:0]   len_i,
  input  wire logic [prrs_pkg::CntW-1:0]   count_i,
  input  wire prrs_pkg::task_state_e       rd_status_i,
  input  wire logic [prrs_pkg::PrioW-1:0]  rd_prio_i,
  output prrs_pkg::scan_stat_t             stat_o
);

  logic [prrs_pkg::IdxW-1:0]  ptr_q, ptr_d;
  logic [prrs_pkg::CntW-1:0]  rem_q, rem_d;
  logic [prrs_pkg::IdxW-1:0]  best_q, best_d;
  logic [prrs_pkg::PrioW-1:0] best_pri_q, best_pri_d;
  logic                       found_q, found_d;
  logic                       hit;
  logic                       better;

  // The single compare: a ready entry with a strictly higher priority wins,
  // so the lowest index keeps a tie.
  assign hit    = (rd_status_i == prrs_pkg::TS_READY);
  assign better = hit && (rd_prio_i > best_pri_q);

  always_comb begin
    stat_o.ptr   = ptr_q;
    stat_o.hit   = hit;
    stat_o.last  = (rem_q == prrs_pkg::CntW'(1));
    stat_o.found = found_q | better;
    stat_o.best  = better ? ptr_q : best_q;
  end

  always_comb begin
    ptr_d      = ptr_q;
    rem_d      = rem_q;
    best_d     = best_q;
    best_pri_d = best_pri_q;
    found_d    = found_q;
    unique case (cmd_i)
      prrs_pkg::SC_HOLD: begin
      end
      prrs_pkg::SC_START_PRI: begin
        ptr_d      = '0;
        rem_d      = len_i;
        best_d     = '0;
        best_pri_d = '0;
        found_d    = 1'b0;
      end
      prrs_pkg::SC_START_RR: begin
        ptr_d = start_i;
        rem_d = len_i;
      end
      prrs_pkg::SC_STEP: begin
        ptr_d = prrs_pkg::wrap_inc(ptr_q, count_i);
        rem_d = rem_q - prrs_pkg::CntW'(1);
        if (better) begin
          best_d     = ptr_q;
          best_pri_d = rd_prio_i;
          found_d    = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q      <= '0;
      rem_q      <= '0;
      best_q     <= '0;
      best_pri_q <= '0;
      found_q    <= 1'b0;
    end else begin
      ptr_q      <= ptr_d;
      rem_q      <= rem_d;
      best_q     <= best_d;
      best_pri_q <= best_pri_d;
      found_q    <= found_d;
    end
  end

endmodule

`default_nettype wire

### design/priority_round_robin_task_scheduler_top.sv
// ----------------------------------------------------------------------------
// priority_round_robin_task_scheduler_top: priority / round-robin scheduler
// Keeps eight task slots with state and priority, the current task, the task
// count and a time-slice counter, and handles one event word at a time.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake                 Word
//  -------  ---------  ------------------------  --------------------------------
//  in       input      in_valid_i / in_ready_o   func, task_index, new_priority,
//                                                new_state
//  out      output     out_valid_o / out_ready_i running_task, switched,
//                                                created_id, status, tasks_in_use
//  cfg      input      cfg_valid_i / cfg_ready_o slice_length
//
// Create, set-state and a tick that does not expire pass through the execute
// and finish states to a valid result. A yield scans the table by priority and
// then, if nothing ready has a nonzero priority, round-robin, one entry per
// cycle through the single table read port and the shared scan unit. An
// expiring tick scans round-robin only. Reset clears the table to terminated
// at once; no clearing pass is needed. A finished word waits in the output
// register while the next event word is accepted; the sequencer stalls only
// when it has a second result and the first has not yet been taken.
// ----------------------------------------------------------------------------
`default_nettype none

module priority_round_robin_task_scheduler_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Event words
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [1:0]                    func_i,
  input  wire logic [prrs_pkg::IdxW-1:0]     task_index_i,
  input  wire logic [prrs_pkg::PrioW-1:0]    new_priority_i,
  input  wire logic [1:0]                    new_state_i,
  // Result words
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [prrs_pkg::IdxW-1:0]          running_task_o,
  output logic                               switched_o,
  output logic [prrs_pkg::IdxW-1:0]          created_id_o,
  output logic [1:0]                         status_o,
  output logic [prrs_pkg::CntW-1:0]          tasks_in_use_o,
  // Slice length register
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [prrs_pkg::SliceW-1:0]   slice_length_i
);

  // Sequencer states.
  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_EXEC   = 7'b0000010,
    S_PSCAN  = 7'b0000100,
    S_RSCAN  = 7'b0001000,
    S_OUTGO  = 7'b0010000,
    S_COMMIT = 7'b0100000,
    S_FINISH = 7'b1000000
  } fsm_e;

  fsm_e                         state_q, state_d;
  logic [prrs_pkg::IdxW-1:0]    cur_q, cur_d;
  logic [prrs_pkg::CntW-1:0]    count_q, count_d;
  logic [prrs_pkg::SliceW-1:0]  slice_left_q, slice_left_d;
  logic [prrs_pkg::SliceW-1:0]  slice_len_q;
  logic [prrs_pkg::SliceW-1:0]  slice_dec;

  // Latched event word and per-event working values.
  prrs_pkg::func_e              func_q;
  logic [prrs_pkg::IdxW-1:0]    tidx_q;
  logic [prrs_pkg::PrioW-1:0]   prio_q;
  prrs_pkg::task_state_e        nst_q;
  logic [prrs_pkg::IdxW-1:0]    old_q;
  logic [prrs_pkg::IdxW-1:0]    target_q, target_d;
  logic [prrs_pkg::IdxW-1:0]    created_q, created_d;
  prrs_pkg::status_e            stat_q, stat_d;

  // Output register.
  logic                         out_valid_q;
  logic [prrs_pkg::IdxW-1:0]    out_task_q;
  logic                         out_switched_q;
  logic [prrs_pkg::IdxW-1:0]    out_created_q;
  prrs_pkg::status_e            out_status_q;
  logic [prrs_pkg::CntW-1:0]    out_count_q;

  logic                         in_accept;
  logic                         out_load;

  prrs_pkg::tbl_wr_t            tbl_wr;
  logic [prrs_pkg::IdxW-1:0]    rd_addr;
  prrs_pkg::task_state_e        rd_status;
  logic [prrs_pkg::PrioW-1:0]   rd_prio;

  prrs_pkg::scan_cmd_e          scan_cmd;
  logic [prrs_pkg::IdxW-1:0]    scan_start;
  logic [prrs_pkg::CntW-1:0]    scan_len;
  prrs_pkg::scan_stat_t         scan_stat;

  prrs_table u_table (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_i        (tbl_wr),
    .rd_addr_i   (rd_addr),
    .rd_status_o (rd_status),
    .rd_prio_o   (rd_prio)
  );

  prrs_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (scan_cmd),
    .start_i     (scan_start),
    .len_i       (scan_len),
    .count_i     (count_q),
    .rd_status_i (rd_status),
    .rd_prio_i   (rd_prio),
    .stat_o      (scan_stat)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_accept   = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_load    = (state_q == S_FINISH) && (!out_valid_q || out_ready_i);

  // The slice counts down but never below zero.
  assign slice_dec = (slice_left_q == '0) ? '0 : slice_left_q - prrs_pkg::SliceW'(1);

  always_comb begin
    state_d      = state_q;
    cur_d        = cur_q;
    count_d      = count_q;
    slice_left_d = slice_left_q;
    target_d     = target_q;
    created_d    = created_q;
    stat_d       = stat_q;
    tbl_wr       = '0;
    rd_addr      = scan_stat.ptr;
    scan_cmd     = prrs_pkg::SC_HOLD;
    scan_start   = prrs_pkg::wrap_inc(cur_q, count_q);
    scan_len     = count_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          created_d = '0;
          stat_d    = prrs_pkg::STAT_OK;
          state_d   = S_EXEC;
        end
      end

      S_EXEC: begin
        rd_addr = cur_q;
        state_d = S_FINISH;
        unique case (func_q)
          prrs_pkg::FUNC_CREATE: begin
            if (count_q == prrs_pkg::CntW'(prrs_pkg::TaskSlots)) begin
              stat_d = prrs_pkg::STAT_FULL;
            end else begin
              tbl_wr.st_we   = 1'b1;
              tbl_wr.addr    = prrs_pkg::IdxW'(count_q);
              tbl_wr.st_data = prrs_pkg::TS_READY;
              tbl_wr.pr_we   = 1'b1;
              tbl_wr.pr_data = prio_q;
              created_d      = prrs_pkg::IdxW'(count_q);
              count_d        = count_q + prrs_pkg::CntW'(1);
            end
          end
          prrs_pkg::FUNC_SET: begin
            if (prrs_pkg::CntW'(tidx_q) >= count_q) begin
              stat_d = prrs_pkg::STAT_RANGE;
            end else begin
              tbl_wr.st_we   = 1'b1;
              tbl_wr.addr    = tidx_q;
              tbl_wr.st_data = nst_q;
            end
          end
          prrs_pkg::FUNC_TICK: begin
            slice_left_d = slice_dec;
            // Only the other tasks are candidates, so one task never switches.
            if (slice_dec == '0 && count_q > prrs_pkg::CntW'(1)) begin
              scan_cmd = prrs_pkg::SC_START_RR;
              scan_len = count_q - prrs_pkg::CntW'(1);
              state_d  = S_RSCAN;
            end
          end
          prrs_pkg::FUNC_YIELD: begin
            if (count_q != '0) begin
              // The yielding task becomes a candidate of its own scan.
              if (rd_status == prrs_pkg::TS_RUNNING) begin
                tbl_wr.st_we   = 1'b1;
                tbl_wr.addr    = cur_q;
                tbl_wr.st_data = prrs_pkg::TS_READY;
              end
              scan_cmd = prrs_pkg::SC_START_PRI;
              state_d  = S_PSCAN;
            end
          end
          default: begin
          end
        endcase
      end

      S_PSCAN: begin
        scan_cmd = prrs_pkg::SC_STEP;
        if (scan_stat.last) begin
          if (scan_stat.found) begin
            target_d = scan_stat.best;
            state_d  = S_COMMIT;
          end else begin
            // All ready tasks have priority zero: fall back to round-robin,
            // which comes back to the current task last.
            scan_cmd = prrs_pkg::SC_START_RR;
            state_d  = S_RSCAN;
          end
        end
      end

      S_RSCAN: begin
        if (scan_stat.hit) begin
          target_d = scan_stat.ptr;
          state_d  = (func_q == prrs_pkg::FUNC_TICK) ? S_OUTGO : S_COMMIT;
        end else if (scan_stat.last) begin
          if (func_q == prrs_pkg::FUNC_TICK) begin
            state_d = S_FINISH;
          end else begin
            target_d = cur_q;
            state_d  = S_COMMIT;
          end
        end else begin
          scan_cmd = prrs_pkg::SC_STEP;
        end
      end

      S_OUTGO: begin
        rd_addr = cur_q;
        if (rd_status == prrs_pkg::TS_RUNNING) begin
          tbl_wr.st_we   = 1'b1;
          tbl_wr.addr    = cur_q;
          tbl_wr.st_data = prrs_pkg::TS_READY;
        end
        state_d = S_COMMIT;
      end

      S_COMMIT: begin
        tbl_wr.st_we   = 1'b1;
        tbl_wr.addr    = target_q;
        tbl_wr.st_data = prrs_pkg::TS_RUNNING;
        cur_d          = target_q;
        slice_left_d   = slice_len_q;
        state_d        = S_FINISH;
      end

      S_FINISH: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cur_q        <= '0;
      count_q      <= '0;
      slice_left_q <= prrs_pkg::SliceReset;
      slice_len_q  <= prrs_pkg::SliceReset;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cur_q        <= cur_d;
      count_q      <= count_d;
      slice_left_q <= slice_left_d;
      if (cfg_valid_i && cfg_ready_o) begin
        slice_len_q <= slice_length_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      func_q <= prrs_pkg::func_e'(func_i);
      tidx_q <= task_index_i;
      prio_q <= new_priority_i;
      nst_q  <= prrs_pkg::task_state_e'(new_state_i);
      old_q  <= cur_q;
    end
    target_q  <= target_d;
    created_q <= created_d;
    stat_q    <= stat_d;
    if (out_load) begin
      out_task_q     <= cur_q;
      out_switched_q <= (cur_q != old_q);
      out_created_q  <= created_q;
      out_status_q   <= stat_q;
      out_count_q    <= count_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign running_task_o = out_task_q;
  assign switched_o     = out_switched_q;
  assign created_id_o   = out_created_q;
  assign status_o       = out_status_q;
  assign tasks_in_use_o = out_count_q;

  // The task count never passes the number of slots.
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= prrs_pkg::CntW'(prrs_pkg::TaskSlots))
    else $error("task count beyond slot count");

  // The current task is always one that has been created.
  a_cur_created : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != '0 |-> prrs_pkg::CntW'(cur_q) < count_q)
    else $error("current task not created");

  // A refused create or set-state never changes the current task.
  a_err_no_switch : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != prrs_pkg::STAT_OK |-> !switched_o)
    else $error("switch reported on a refused event");

  // The scan pointer stays inside the created tasks while scanning.
  a_scan_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PSCAN || state_q == S_RSCAN) |->
      prrs_pkg::CntW'(scan_stat.ptr) < count_q)
    else $error("scan pointer beyond task count");

endmodule

`default_nettype wire
